FILE: rtl/core/cpc_pkg.sv
// ============================================================================
// cpc_pkg
// Shared types and constants for the circle pixel coverage block.
// ============================================================================
`default_nettype none

package cpc_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_CENTER_X    = 3'd0;
    localparam logic [2:0] CFG_CENTER_Y    = 3'd1;
    localparam logic [2:0] CFG_RADIUS      = 3'd2;
    localparam logic [2:0] CFG_FILL_COLOR  = 3'd3;
    localparam logic [2:0] CFG_MULTISAMPLE = 3'd4;
    localparam logic [2:0] CFG_IMG_WIDTH   = 3'd5;
    localparam logic [2:0] CFG_IMG_HEIGHT  = 3'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int COORD_W     = 12;
    localparam int CENTER_W    = 14;
    localparam int RADIUS_W    = 16;
    localparam int COLOR_W     = 32;
    localparam int SIZE_W      = 13;

    // quarter-pixel offsets and squared distances
    localparam int DELTA_W = 18;
    localparam int SQ_W    = 32;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [12:0] IMG_SIZE_RESET = 13'd4096;

    typedef struct packed {
        logic signed [CENTER_W-1:0] center_x;
        logic signed [CENTER_W-1:0] center_y;
        logic [RADIUS_W-1:0]        radius_quarters;
        logic [COLOR_W-1:0]         fill_color;
        logic                       multisample_on;
        logic [SIZE_W-1:0]          image_width;
        logic [SIZE_W-1:0]          image_height;
    } cfg_t;

    // classified item handed from front to back
    typedef struct packed {
        logic [COORD_W-1:0]        col;
        logic [COORD_W-1:0]        row;
        logic                      in_box;
        logic signed [DELTA_W-1:0] dx_a;
        logic signed [DELTA_W-1:0] dx_b;
        logic signed [DELTA_W-1:0] dy_a;
        logic signed [DELTA_W-1:0] dy_b;
    } item_t;

endpackage

`default_nettype wire

FILE: rtl/core/cpc_front.sv
// ============================================================================
// cpc_front
// Accepts pixel beats, checks the clipped bounding box and forms the
// quarter-pixel offsets of the sample points from the circle center.
// ============================================================================
`default_nettype none

module cpc_front #(
    parameter int IMAGE_SIZE_MAX = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cpc_pkg::cfg_t                 cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [cpc_pkg::COORD_W-1:0]   pixel_col,
    input  wire logic [cpc_pkg::COORD_W-1:0]   pixel_row,
    output logic                               push,
    output cpc_pkg::item_t                     push_item,
    input  wire logic                          queue_full
);

    localparam int DW = cpc_pkg::DELTA_W;
    localparam logic signed [DW-1:0] LIM_MAX = DW'(IMAGE_SIZE_MAX);

    logic           front_valid_reg;
    logic           front_valid_next;
    cpc_pkg::item_t front_item_reg;
    cpc_pkg::item_t front_item_next;
    logic           take;
    logic signed [DW-1:0] off_a;

    // one box axis: lo = max(0, floor((4c-r)/4)), hi = min(lim, floor((4c+r)/4))
    function automatic logic span_hit(
        input logic signed [cpc_pkg::CENTER_W-1:0] c,
        input logic [cpc_pkg::RADIUS_W-1:0]        r,
        input logic [cpc_pkg::SIZE_W-1:0]          limit,
        input logic [cpc_pkg::COORD_W-1:0]         pos
    );
        logic signed [DW-1:0] c4;
        logic signed [DW-1:0] rr;
        logic signed [DW-1:0] lo4;
        logic signed [DW-1:0] hi4;
        logic signed [DW-1:0] lo;
        logic signed [DW-1:0] hi;
        logic signed [DW-1:0] lim;
        logic signed [DW-1:0] p;
        c4  = $signed({{2{c[cpc_pkg::CENTER_W-1]}}, c, 2'b00});
        rr  = $signed({2'b00, r});
        lo4 = c4 - rr;
        hi4 = c4 + rr;
        lo  = lo4[DW-1] ? '0 : (lo4 >>> 2);
        hi  = hi4 >>> 2;
        lim = $signed({5'b0, limit});
        if (lim > LIM_MAX)
        begin
            lim = LIM_MAX;
        end
        if (hi > lim)
        begin
            hi = lim;
        end
        p = $signed({6'b0, pos});
        span_hit = (hi4 > 0) && (hi > lo) && (p >= lo) && (p < hi);
    endfunction

    function automatic logic signed [DW-1:0] delta(
        input logic [cpc_pkg::COORD_W-1:0]         pos,
        input logic signed [DW-1:0]                off,
        input logic signed [cpc_pkg::CENTER_W-1:0] c
    );
        logic signed [DW-1:0] p4;
        logic signed [DW-1:0] c4;
        p4 = $signed({4'b0, pos, 2'b00});
        c4 = $signed({{2{c[cpc_pkg::CENTER_W-1]}}, c, 2'b00});
        delta = p4 + off - c4;
    endfunction

    assign push     = front_valid_reg && !queue_full;
    assign in_ready = !front_valid_reg || !queue_full;
    assign take     = in_valid && in_ready;
    assign push_item = front_item_reg;

    // single-sample tests the corner; four-sample uses 1/4 and 3/4
    assign off_a = cfg.multisample_on ? DW'(1) : '0;

    always_comb
    begin
        front_valid_next = front_valid_reg;
        front_item_next  = front_item_reg;
        if (take)
        begin
            front_valid_next       = 1'b1;
            front_item_next.col    = pixel_col;
            front_item_next.row    = pixel_row;
            front_item_next.in_box =
                span_hit(cfg.center_x, cfg.radius_quarters, cfg.image_width, pixel_col) &&
                span_hit(cfg.center_y, cfg.radius_quarters, cfg.image_height, pixel_row);
            front_item_next.dx_a   = delta(pixel_col, off_a, cfg.center_x);
            front_item_next.dx_b   = delta(pixel_col, DW'(3), cfg.center_x);
            front_item_next.dy_a   = delta(pixel_row, off_a, cfg.center_y);
            front_item_next.dy_b   = delta(pixel_row, DW'(3), cfg.center_y);
        end
        else if (push)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_item_reg <= front_item_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/cpc_queue.sv
// ============================================================================
// cpc_queue
// Short FIFO between the classify front and the coverage back.
// ============================================================================
`default_nettype none

module cpc_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire cpc_pkg::item_t push_item,
    output logic                full,
    output logic                pop_valid,
    output cpc_pkg::item_t      pop_item,
    input  wire logic           pop
);

    localparam int DEPTH = cpc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cpc_pkg::item_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> pop_valid)
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/cpc_back.sv
// ============================================================================
// cpc_back
// Squares the sample offsets, compares against the squared radius, counts
// coverage and forms the output color.
// ============================================================================
`default_nettype none

module cpc_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cpc_pkg::cfg_t               cfg,
    input  wire logic                        pop_valid,
    input  wire cpc_pkg::item_t              pop_item,
    output logic                             pop,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             write_pixel,
    output logic [cpc_pkg::COORD_W-1:0]      out_col,
    output logic [cpc_pkg::COORD_W-1:0]      out_row,
    output logic [cpc_pkg::COLOR_W-1:0]      out_color
);

    localparam int SQ_W = cpc_pkg::SQ_W;
    localparam int DW   = cpc_pkg::DELTA_W;

    // stage 1: squares
    logic                        s1_valid_reg;
    logic [cpc_pkg::COORD_W-1:0] s1_col_reg;
    logic [cpc_pkg::COORD_W-1:0] s1_row_reg;
    logic                        s1_in_box_reg;
    logic [SQ_W-1:0]             sq_xa_reg;
    logic [SQ_W-1:0]             sq_xb_reg;
    logic [SQ_W-1:0]             sq_ya_reg;
    logic [SQ_W-1:0]             sq_yb_reg;
    logic [SQ_W-1:0]             r2_reg;

    // stage 2: result register
    logic                        out_valid_reg;
    logic                        write_reg;
    logic                        write_next;
    logic [cpc_pkg::COORD_W-1:0] col_reg;
    logic [cpc_pkg::COORD_W-1:0] row_reg;
    logic [cpc_pkg::COLOR_W-1:0] color_reg;
    logic [cpc_pkg::COLOR_W-1:0] color_next;

    logic            s2_adv;
    logic            s1_take;
    logic            s1_move;
    logic [SQ_W:0]   d_aa;
    logic [SQ_W:0]   d_ab;
    logic [SQ_W:0]   d_ba;
    logic [SQ_W:0]   d_bb;
    logic [3:0]      hits;
    logic [2:0]      count;
    logic [9:0]      alpha_prod;

    function automatic logic [SQ_W-1:0] square(input logic signed [DW-1:0] d);
        logic signed [2*DW-1:0] p;
        p = d * d;
        square = p[SQ_W-1:0];
    endfunction

    assign s2_adv  = !out_valid_reg || out_ready;
    assign s1_move = s1_valid_reg && s2_adv;
    assign s1_take = !s1_valid_reg || s2_adv;
    assign pop     = pop_valid && s1_take;

    // x lane a pairs with y lane a for the single-sample corner
    assign d_aa = {1'b0, sq_xa_reg} + {1'b0, sq_ya_reg};
    assign d_ab = {1'b0, sq_xa_reg} + {1'b0, sq_yb_reg};
    assign d_ba = {1'b0, sq_xb_reg} + {1'b0, sq_ya_reg};
    assign d_bb = {1'b0, sq_xb_reg} + {1'b0, sq_yb_reg};

    assign hits[0] = d_aa <= {1'b0, r2_reg};
    assign hits[1] = d_ab <= {1'b0, r2_reg};
    assign hits[2] = d_ba <= {1'b0, r2_reg};
    assign hits[3] = d_bb <= {1'b0, r2_reg};

    assign count = 3'(hits[0]) + 3'(hits[1]) + 3'(hits[2]) + 3'(hits[3]);
    assign alpha_prod = cfg.fill_color[31:24] * count;

    always_comb
    begin
        write_next = 1'b0;
        color_next = '0;
        if (s1_in_box_reg)
        begin
            if (!cfg.multisample_on)
            begin
                if (hits[0])
                begin
                    write_next = 1'b1;
                    color_next = cfg.fill_color;
                end
            end
            else if (count != '0)
            begin
                write_next = 1'b1;
                color_next = {alpha_prod[9:2], cfg.fill_color[23:0]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_take)
            begin
                s1_valid_reg <= pop_valid;
            end
            if (s2_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        r2_reg <= cfg.radius_quarters * cfg.radius_quarters;
        if (pop)
        begin
            s1_col_reg    <= pop_item.col;
            s1_row_reg    <= pop_item.row;
            s1_in_box_reg <= pop_item.in_box;
            sq_xa_reg     <= square(pop_item.dx_a);
            sq_xb_reg     <= square(pop_item.dx_b);
            sq_ya_reg     <= square(pop_item.dy_a);
            sq_yb_reg     <= square(pop_item.dy_b);
        end
        if (s1_move)
        begin
            write_reg <= write_next;
            col_reg   <= s1_col_reg;
            row_reg   <= s1_row_reg;
            color_reg <= color_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign write_pixel = write_reg;
    assign out_col     = col_reg;
    assign out_row     = row_reg;
    assign out_color   = color_reg;

`ifndef SYNTHESIS
    a_no_write_zero_color: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !write_reg) |-> (color_reg == '0))
        else $error("color set on a pixel that is not written");

    a_s1_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |=> s1_valid_reg)
        else $error("stage 1 item lost under output stall");

    a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_adv) |-> !pop)
        else $error("queue popped while stage 1 is blocked");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/circle_pixel_coverage.sv
// ============================================================================
// circle_pixel_coverage
// Tests scanned pixels against a filled circle, one or four samples a pixel.
// ============================================================================
//
//  Channel  Signals                                   Dir  Beat
//  -------  ----------------------------------------  ---  --------------------
//  pixel    in_valid/in_ready, pixel_col, pixel_row   in   one pixel to test
//  result   out_valid/out_ready, write_pixel,         out  one result per pixel
//           out_col, out_row, out_color
//  config   cfg_we, cfg_index, cfg_data               in   one register write
//
//  One pixel per cycle sustained while out_ready stays high; an accepted pixel
//  passes the front register, the queue, the squaring stage and the
//  compare/result register before its result beat goes out.
//  The rate is set by the four squarers in the back, one pass per pixel.
//  Reset clears config to its defaults (image size 4096) and empties all stages.
//  An output stall backs up the back stages, then the two-entry queue, then
//  the front; in_ready drops only when the front register cannot drain.
//
`default_nettype none

module circle_pixel_coverage #(
    parameter int IMAGE_SIZE_MAX = 4096
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [cpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [cpc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [cpc_pkg::COORD_W-1:0]        pixel_col,
    input  wire logic [cpc_pkg::COORD_W-1:0]        pixel_row,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    write_pixel,
    output logic [cpc_pkg::COORD_W-1:0]             out_col,
    output logic [cpc_pkg::COORD_W-1:0]             out_row,
    output logic [cpc_pkg::COLOR_W-1:0]             out_color
);

    cpc_pkg::cfg_t  cfg_reg;
    cpc_pkg::cfg_t  cfg_next;
    logic           push;
    cpc_pkg::item_t push_item;
    logic           queue_full;
    logic           pop_valid;
    cpc_pkg::item_t pop_item;
    logic           pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                cpc_pkg::CFG_CENTER_X:
                    cfg_next.center_x = $signed(cfg_data[cpc_pkg::CENTER_W-1:0]);
                cpc_pkg::CFG_CENTER_Y:
                    cfg_next.center_y = $signed(cfg_data[cpc_pkg::CENTER_W-1:0]);
                cpc_pkg::CFG_RADIUS:
                    cfg_next.radius_quarters = cfg_data[cpc_pkg::RADIUS_W-1:0];
                cpc_pkg::CFG_FILL_COLOR:
                    cfg_next.fill_color = cfg_data[cpc_pkg::COLOR_W-1:0];
                cpc_pkg::CFG_MULTISAMPLE:
                    cfg_next.multisample_on = cfg_data[0];
                cpc_pkg::CFG_IMG_WIDTH:
                    cfg_next.image_width = cfg_data[cpc_pkg::SIZE_W-1:0];
                cpc_pkg::CFG_IMG_HEIGHT:
                    cfg_next.image_height = cfg_data[cpc_pkg::SIZE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x        <= '0;
            cfg_reg.center_y        <= '0;
            cfg_reg.radius_quarters <= '0;
            cfg_reg.fill_color      <= '0;
            cfg_reg.multisample_on  <= 1'b0;
            cfg_reg.image_width     <= cpc_pkg::IMG_SIZE_RESET;
            cfg_reg.image_height    <= cpc_pkg::IMG_SIZE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    cpc_front #(
        .IMAGE_SIZE_MAX (IMAGE_SIZE_MAX)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel_col  (pixel_col),
        .pixel_row  (pixel_row),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    cpc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .pop       (pop)
    );

    cpc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .pop_valid   (pop_valid),
        .pop_item    (pop_item),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .write_pixel (write_pixel),
        .out_col     (out_col),
        .out_row     (out_row),
        .out_color   (out_color)
    );

endmodule

`default_nettype wire

FILE: sim/circle_pixel_coverage_tb.sv
// ============================================================================
// circle_pixel_coverage_tb
// Self-checking bench for the circle pixel coverage block. It steps through
// a series of circle setups, scans pixels near and around each bounding box
// and checks every result beat against a local fixed-point coverage model.
// Sender gaps and receiver stalls come in random bursts.
// ============================================================================
`default_nettype none

module circle_pixel_coverage_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIZE_CAP    = 4096;
    localparam int PIPE_LAT    = 4;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SCAN_ITEMS  = 950;

    typedef logic [cpc_pkg::COORD_W-1:0] coord_t;
    typedef logic [cpc_pkg::COLOR_W-1:0] color_t;

    typedef struct {
        bit     wr;
        coord_t col;
        coord_t row;
        color_t color;
    } pixel_write_t;

    // Mirror of the circle registers plus the queue of pixel writes in flight.
    class coverage_book;
        int                 cx;
        int                 cy;
        longint             radius;
        color_t             fill;
        bit                 multi;
        longint             width;
        longint             height;
        longint             size_cap;
        pixel_write_t       pending_writes[$];
        int                 fails;
        int                 n_pixels;
        int                 n_written;
        int                 n_faded;

        function new(int cap);
            size_cap = cap;
            cx       = 0;
            cy       = 0;
            radius   = 0;
            fill     = '0;
            multi    = 0;
            width    = 4096;
            height   = 4096;
        endfunction

        function void set_reg(logic [cpc_pkg::CFG_INDEX_W-1:0] idx,
                              logic [cpc_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                cpc_pkg::CFG_CENTER_X:
                    cx     = int'($signed(data[cpc_pkg::CENTER_W-1:0]));
                cpc_pkg::CFG_CENTER_Y:
                    cy     = int'($signed(data[cpc_pkg::CENTER_W-1:0]));
                cpc_pkg::CFG_RADIUS:
                    radius = longint'(data[cpc_pkg::RADIUS_W-1:0]);
                cpc_pkg::CFG_FILL_COLOR:
                    fill   = data;
                cpc_pkg::CFG_MULTISAMPLE:
                    multi  = data[0];
                cpc_pkg::CFG_IMG_WIDTH:
                    width  = longint'(data[cpc_pkg::SIZE_W-1:0]);
                cpc_pkg::CFG_IMG_HEIGHT:
                    height = longint'(data[cpc_pkg::SIZE_W-1:0]);
                default: ;
            endcase
        endfunction

        // Box test on one axis, all in quarter pixels until the final divide.
        function bit in_box(longint c, longint limit, longint pos);
            longint lo4;
            longint hi4;
            longint lo;
            longint hi;
            longint lim;
            lim = (limit > size_cap) ? size_cap : limit;
            lo4 = c * 4 - radius;
            hi4 = c * 4 + radius;
            if (hi4 <= 0)
                return 0;
            lo = (lo4 < 0) ? 0 : lo4 / 4;
            hi = hi4 / 4;
            if (hi > lim)
                hi = lim;
            if (hi <= lo)
                return 0;
            return (pos >= lo) && (pos < hi);
        endfunction

        function bit covers(longint px4, longint py4);
            longint dx;
            longint dy;
            dx = px4 - longint'(cx) * 4;
            dy = py4 - longint'(cy) * 4;
            return (dx * dx + dy * dy) <= radius * radius;
        endfunction

        function void note_pixel(coord_t col, coord_t row);
            pixel_write_t e;
            longint       bx;
            longint       by;
            int           hits;
            int unsigned  alpha;
            e.wr    = 0;
            e.col   = col;
            e.row   = row;
            e.color = '0;
            bx      = longint'(col) * 4;
            by      = longint'(row) * 4;
            hits    = 0;
            n_pixels++;
            if (in_box(cx, width, longint'(col)) && in_box(cy, height, longint'(row))) begin
                if (!multi) begin
                    if (covers(bx, by)) begin
                        e.wr    = 1;
                        e.color = fill;
                    end
                end else begin
                    for (int i = 0; i < 2; i++)
                        for (int j = 0; j < 2; j++)
                            if (covers(bx + 1 + 2 * i, by + 1 + 2 * j))
                                hits++;
                    if (hits != 0) begin
                        alpha   = (int'(fill[31:24]) * hits) / 4;
                        e.wr    = 1;
                        e.color = {alpha[7:0], fill[23:0]};
                        if (hits < 4)
                            n_faded++;
                    end
                end
            end
            if (e.wr)
                n_written++;
            pending_writes.push_back(e);
        endfunction

        function void check_result(logic wr, coord_t col, coord_t row, color_t color);
            pixel_write_t e;
            if (pending_writes.size() == 0) begin
                $error("unexpected result beat: col %0d row %0d", col, row);
                fails++;
                return;
            end
            e = pending_writes.pop_front();
            if (wr !== e.wr) begin
                $error("write_pixel: expected %0d, got %0d", e.wr, wr);
                fails++;
            end
            if (col !== e.col) begin
                $error("out_col: expected %0d, got %0d", e.col, col);
                fails++;
            end
            if (row !== e.row) begin
                $error("out_row: expected %0d, got %0d", e.row, row);
                fails++;
            end
            if (color !== e.color) begin
                $error("out_color: expected %08h, got %08h", e.color, color);
                fails++;
            end
        endfunction

        function int pending();
            return pending_writes.size();
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [cpc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [cpc_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                            in_valid;
    logic                            in_ready;
    coord_t                          pixel_col;
    coord_t                          pixel_row;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic                            write_pixel;
    coord_t                          out_col;
    coord_t                          out_row;
    color_t                          out_color;

    coverage_book  book;
    cpc_pkg::cfg_t cur_setup;
    int            gap_pct;
    int            stall_pct;
    int            stall_left = 0;
    bit            calm;
    int            cycle_count;
    int            n_setups;

    circle_pixel_coverage #(
        .IMAGE_SIZE_MAX (SIZE_CAP)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel_col   (pixel_col),
        .pixel_row   (pixel_row),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .write_pixel (write_pixel),
        .out_col     (out_col),
        .out_row     (out_row),
        .out_color   (out_color)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            book.check_result(write_pixel, out_col, out_row, out_color);
    end

    // result side back-pressure, in bursts
    always @(negedge clk)
    begin
        if (!calm && stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!calm && rst_n && $urandom_range(99) < stall_pct)
        begin
            stall_left = $urandom_range(17, 0);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    function automatic cpc_pkg::cfg_t setup_of(int cx, int cy, int unsigned r,
                                               logic [31:0] color, bit ms,
                                               int unsigned w, int unsigned h);
        cpc_pkg::cfg_t s;
        s.center_x        = cx[cpc_pkg::CENTER_W-1:0];
        s.center_y        = cy[cpc_pkg::CENTER_W-1:0];
        s.radius_quarters = r[cpc_pkg::RADIUS_W-1:0];
        s.fill_color      = color;
        s.multisample_on  = ms;
        s.image_width     = w[cpc_pkg::SIZE_W-1:0];
        s.image_height    = h[cpc_pkg::SIZE_W-1:0];
        return s;
    endfunction

    function automatic int unsigned pick_size();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 7)
            return 4096;
        if (sel == 7)
            return $urandom_range(4096, 0);
        if (sel == 8)
            return $urandom_range(8191, 0);
        case ($urandom_range(4))
            0:       return 0;
            1:       return 1;
            2:       return 4095;
            3:       return 4097;
            default: return 8191;
        endcase
    endfunction

    function automatic int pick_center();
        case ($urandom_range(9))
            0:       return -8192;
            1:       return 8191;
            2:       return int'($urandom_range(16383, 0)) - 8192;
            default: return int'($urandom_range(4200, 0)) - 100;
        endcase
    endfunction

    function automatic cpc_pkg::cfg_t random_setup();
        int unsigned r;
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 6)
            r = $urandom_range(400, 0);
        else if (sel < 8)
            r = $urandom_range(16, 0);
        else if (sel == 8)
            r = $urandom_range(65535, 0);
        else
            r = $urandom_range(1) ? 65535 : 0;
        return setup_of(pick_center(), pick_center(), r, $urandom, 1'($urandom_range(1)),
                        pick_size(), pick_size());
    endfunction

    // mostly a coordinate in or just around the box on one axis, sometimes anywhere
    function automatic coord_t pick_coord(int c, int r);
        int lo;
        int hi;
        lo = c - r / 4 - 2;
        hi = c + r / 4 + 3;
        if (lo < 0)
            lo = 0;
        if (hi > 4095)
            hi = 4095;
        if (lo > hi || $urandom_range(9) < 2)
            return coord_t'($urandom_range(4095, 0));
        return coord_t'($urandom_range(hi, lo));
    endfunction

    task automatic write_reg(input logic [cpc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [cpc_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        book.set_reg(idx, data);
    endtask

    // all seven registers, unused upper data bits sometimes filled with junk
    task automatic load_setup(input cpc_pkg::cfg_t s);
        logic [31:0] junk;
        junk = $urandom_range(1) ? $urandom : 32'd0;
        write_reg(cpc_pkg::CFG_CENTER_X, {junk[31:cpc_pkg::CENTER_W], s.center_x});
        write_reg(cpc_pkg::CFG_CENTER_Y, {junk[31:cpc_pkg::CENTER_W], s.center_y});
        write_reg(cpc_pkg::CFG_RADIUS, {junk[31:cpc_pkg::RADIUS_W], s.radius_quarters});
        write_reg(cpc_pkg::CFG_FILL_COLOR, s.fill_color);
        write_reg(cpc_pkg::CFG_MULTISAMPLE, {junk[31:1], s.multisample_on});
        write_reg(cpc_pkg::CFG_IMG_WIDTH, {junk[31:cpc_pkg::SIZE_W], s.image_width});
        write_reg(cpc_pkg::CFG_IMG_HEIGHT, {junk[31:cpc_pkg::SIZE_W], s.image_height});
        cfg_we    <= 1'b0;
        cur_setup = s;
        n_setups++;
    endtask

    // called and returns on a falling edge
    task automatic send_pixel(input coord_t col, input coord_t row);
        int gap;
        if (!calm && $urandom_range(99) < gap_pct)
        begin
            gap = $urandom_range(18, 1);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        pixel_col <= col;
        pixel_row <= row;
        do
            @(posedge clk);
        while (!in_ready);
        book.note_pixel(col, row);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (book.pending() != 0)
            @(negedge clk);
        repeat (PIPE_LAT + 2) @(negedge clk);
    endtask

    task automatic pick_pressure();
        case ($urandom_range(3))
            0:       gap_pct = 0;
            1:       gap_pct = 10;
            2:       gap_pct = 30;
            default: gap_pct = 60;
        endcase
        case ($urandom_range(3))
            0:       stall_pct = 0;
            1:       stall_pct = 10;
            2:       stall_pct = 30;
            default: stall_pct = 60;
        endcase
    endtask

    initial
    begin
        int scanned;
        int n;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        pixel_col  = '0;
        pixel_row  = '0;
        gap_pct    = 20;
        stall_pct  = 20;
        calm       = 0;
        book       = new(SIZE_CAP);
        cur_setup  = setup_of(0, 0, 0, 0, 0, 4096, 4096);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset setup: zero radius gives an empty box
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        settle();

        // 5 px circle, corner samples, exact rim and excluded box end
        load_setup(setup_of(10, 10, 20, 32'hFF123456, 0, 4096, 4096));
        send_pixel(10, 10);
        send_pixel(5, 10);
        send_pixel(10, 5);
        send_pixel(14, 10);
        send_pixel(15, 10);
        send_pixel(6, 6);
        send_pixel(4, 10);
        settle();

        // same circle, four samples: full and partial coverage
        load_setup(setup_of(10, 10, 20, 32'hFF123456, 1, 4096, 4096));
        send_pixel(10, 10);
        send_pixel(13, 13);
        send_pixel(14, 12);
        send_pixel(14, 13);
        send_pixel(5, 10);
        settle();

        // extreme center and radius, image size past the cap
        load_setup(setup_of(-8192, 8191, 65535, 32'h80ABCDEF, 1, 8191, 4097));
        send_pixel(0, 4095);
        send_pixel(4095, 0);
        send_pixel(4095, 4095);
        settle();

        // zero image width empties the box
        load_setup(setup_of(2000, 2000, 65535, 32'hFFFFFFFF, 0, 0, 4096));
        send_pixel(0, 0);
        send_pixel(1999, 2000);
        settle();

        // sub-pixel radius at the far corner, alpha rounds to zero
        load_setup(setup_of(4095, 4095, 3, 32'h03FFFFFF, 1, 4096, 4096));
        send_pixel(4094, 4094);
        send_pixel(4095, 4095);
        settle();

        scanned = 0;
        while (scanned < SCAN_ITEMS)
        begin
            if (scanned > SCAN_ITEMS - 170)
                calm = 1;
            pick_pressure();
            load_setup(random_setup());
            n = $urandom_range(60, 15);
            repeat (n)
            begin
                send_pixel(pick_coord(int'(cur_setup.center_x), int'(cur_setup.radius_quarters)),
                           pick_coord(int'(cur_setup.center_y), int'(cur_setup.radius_quarters)));
                scanned++;
            end
            settle();
        end

        repeat (2 * PIPE_LAT) @(negedge clk);
        $display("scanned %0d pixels over %0d circle setups", book.n_pixels, n_setups);
        $display("%0d pixels written, %0d of them with reduced alpha",
                 book.n_written, book.n_faded);
        if (book.fails == 0 && book.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: circle_pixel_coverage.f
rtl/core/cpc_pkg.sv
rtl/core/cpc_front.sv
rtl/core/cpc_queue.sv
rtl/core/cpc_back.sv
rtl/core/circle_pixel_coverage.sv
sim/circle_pixel_coverage_tb.sv
